// ----- sv/pts_pkg.sv -----
// pts_pkg: shared types, sizes and codes for the priority thread scheduler
// used by pts_ctrl, pts_dpath and priority_thread_scheduler
`timescale 1ns / 1ps

package pts_pkg;

    localparam int THREADS   = 8;
    localparam int SLOT_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int RUN_W     = 4;
    localparam int PRIO_W    = 5;
    localparam int TICKS_W   = 32;
    localparam int FUNC_W    = 2;
    localparam int MASK_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 16;

    localparam logic [RUN_W-1:0]  IDLE_SLOT = RUN_W'(THREADS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREADS - 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_DELAY      = 2'd1,
        FUNC_TICK       = 2'd2,
        FUNC_RESCHEDULE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_TAKEN      = 2'd2,
        ST_IDLE_DELAY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_PICK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic tick_step;
        logic pick;
        logic load_out;
    } pts_cmd_t;

    typedef struct packed {
        func_t func;
        logic  walk_last;
    } pts_stat_t;

endpackage

// ----- sv/pts_ctrl.sv -----
// pts_ctrl: sequencer for one event at a time and the result word valid flag
// depends on pts_pkg
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pts_cmd_t  cmd,
    input  pts_stat_t stat
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                case (stat.func)
                    FUNC_REGISTER: state_next = S_DONE;
                    FUNC_TICK:     state_next = S_TICK;
                    default:       state_next = S_PICK;
                endcase
            end
            S_TICK: begin
                // one counter per cycle
                cmd.tick_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- sv/pts_dpath.sv -----
// pts_dpath: slot table, ready mask, delay counters, selection and result register
// depends on pts_pkg
`timescale 1ns / 1ps

module pts_dpath
    import pts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [PRIO_W-1:0]   in_prio,
    input  logic [TICKS_W-1:0]  in_ticks,
    input  pts_cmd_t            cmd,
    output pts_stat_t           stat,
    output logic [RUN_W-1:0]    out_thread,
    output logic [MASK_W-1:0]   out_mask,
    output logic [STATUS_W-1:0] out_status
);

    func_t                func_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    logic [THREADS-1:0]   ready_reg;
    logic [THREADS-1:0]   used_reg;
    logic [TICKS_W-1:0]   count_reg [THREADS];
    logic [RUN_W-1:0]     run_reg;
    status_t              status_reg;
    logic [SLOT_W-1:0]    walk_reg;
    logic [RUN_W-1:0]     out_thread_reg;
    logic [MASK_W-1:0]    out_mask_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [SLOT_W-1:0]    prio_idx;
    logic [SLOT_W-1:0]    run_idx;
    logic [TICKS_W-1:0]   walk_count;
    logic [RUN_W-1:0]     pick_slot;
    logic [MASK_W-1:0]    mask_view;

    assign prio_idx   = prio_reg[SLOT_W-1:0];
    assign run_idx    = run_reg[SLOT_W-1:0];
    assign walk_count = count_reg[walk_reg];

    // lowest-numbered ready slot wins
    always_comb begin
        pick_slot = IDLE_SLOT;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (ready_reg[i]) begin
                pick_slot = RUN_W'(i);
            end
        end
    end

    always_comb begin
        mask_view = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < THREADS) begin
                mask_view[i] = ready_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= func_t'(in_func);
            prio_reg  <= in_prio;
            ticks_reg <= in_ticks;
        end
        if (cmd.load_out) begin
            out_thread_reg <= run_reg;
            out_mask_reg   <= mask_view;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg  <= '0;
            used_reg   <= '0;
            run_reg    <= IDLE_SLOT;
            status_reg <= ST_OK;
            walk_reg   <= '0;
            for (int i = 0; i < THREADS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.load_in) begin
                walk_reg   <= '0;
                status_reg <= ST_OK;
            end
            if (cmd.exec) begin
                case (func_reg)
                    FUNC_REGISTER: begin
                        if (prio_reg >= PRIO_W'(THREADS)) begin
                            status_reg <= ST_RANGE;
                        end else if (used_reg[prio_idx]) begin
                            status_reg <= ST_TAKEN;
                        end else begin
                            used_reg[prio_idx]  <= 1'b1;
                            ready_reg[prio_idx] <= 1'b1;
                        end
                    end
                    FUNC_DELAY: begin
                        if (run_reg == IDLE_SLOT) begin
                            status_reg <= ST_IDLE_DELAY;
                        end else begin
                            count_reg[run_idx] <= ticks_reg;
                            ready_reg[run_idx] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.tick_step) begin
                if (used_reg[walk_reg] && (walk_count != '0)) begin
                    count_reg[walk_reg] <= walk_count - TICKS_W'(1);
                    if (walk_count == TICKS_W'(1)) begin
                        ready_reg[walk_reg] <= 1'b1;
                    end
                end
                walk_reg <= walk_reg + SLOT_W'(1);
            end
            if (cmd.pick) begin
                run_reg <= pick_slot;
            end
        end
    end

    assign stat.func      = func_reg;
    assign stat.walk_last = (walk_reg == LAST_SLOT);
    assign out_thread     = out_thread_reg;
    assign out_mask       = out_mask_reg;
    assign out_status     = out_status_reg;

endmodule

// ----- sv/priority_thread_scheduler.sv -----
// priority_thread_scheduler: one event word in, one result word out
// an accepted word passes S_EXEC, then S_DONE for a register event, S_PICK and S_DONE for delay and
// reschedule, or S_TICK, S_PICK and S_DONE for a tick; the tick walks the delay counters one per cycle
// one event in flight: no new word is accepted until the result word of the last one is loaded
// reset (aresetn low, synchronous): no slots, nothing ready, counters zero, idle thread
// depends on pts_pkg, pts_ctrl, pts_dpath
`timescale 1ns / 1ps

module priority_thread_scheduler
    import pts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // priority_req[4:0], delay_ticks[36:5], zero[39:37]
    input  logic [FUNC_W-1:0]   s_tuser,   // func[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // current_thread[3:0], ready_mask[11:4], status[13:12]
);

    pts_cmd_t            cmd;
    pts_stat_t           stat;
    logic [RUN_W-1:0]    out_thread;
    logic [MASK_W-1:0]   out_mask;
    logic [STATUS_W-1:0] out_status;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pts_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_func    (s_tuser),
        .in_prio    (s_tdata[PRIO_W-1:0]),
        .in_ticks   (s_tdata[PRIO_W+TICKS_W-1:PRIO_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_thread (out_thread),
        .out_mask   (out_mask),
        .out_status (out_status)
    );

    assign m_tdata = {2'b00, out_status, out_mask, out_thread};

    // a running thread always has its ready bit set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_thread != IDLE_SLOT) |-> out_mask[out_thread[SLOT_W-1:0]])
        else $error("running thread not marked ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_thread <= IDLE_SLOT)
        else $error("current thread beyond idle slot");

    // an accepted word passes S_EXEC before s_tready returns or its result appears
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("event accepted while another is in flight");

    // range and taken codes only come from a register event, which never reschedules
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && (stat.func != FUNC_REGISTER)
        |=> (out_status != ST_RANGE) && (out_status != ST_TAKEN))
        else $error("register status on a non-register event");

endmodule

// ----- sim/tb_priority_thread_scheduler.sv -----
// tb_priority_thread_scheduler: self-checking bench for the priority thread scheduler
// drives event words, predicts every result word in a small class and compares field by field
// depends on pts_pkg and priority_thread_scheduler
`timescale 1ns / 1ps

module tb_priority_thread_scheduler;
    import pts_pkg::*;

    typedef struct {
        logic [RUN_W-1:0]  thread;
        logic [MASK_W-1:0] mask;
        status_t           status;
    } sched_word_t;

    // tracks the scheduler state and the result words still owed by the block
    class sched_predictor;
        logic [MASK_W-1:0]  ready_bits;
        bit                 slot_used [THREADS];
        logic [TICKS_W-1:0] delay_left [THREADS];
        logic [RUN_W-1:0]   running;
        sched_word_t        owed_words [$];
        int                 errors;
        int                 words_checked;
        int                 wakeups;
        int                 func_count [4];
        int                 status_count [4];

        function new();
            ready_bits = '0;
            running    = IDLE_SLOT;
            errors     = 0;
            words_checked = 0;
            wakeups    = 0;
            for (int i = 0; i < THREADS; i++) begin
                slot_used[i]  = 1'b0;
                delay_left[i] = '0;
            end
            for (int i = 0; i < 4; i++) begin
                func_count[i]   = 0;
                status_count[i] = 0;
            end
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // lowest-numbered ready slot wins, idle thread when none is ready
        function void pick_next();
            running = IDLE_SLOT;
            for (int i = THREADS - 1; i >= 0; i--) begin
                if (ready_bits[i]) running = RUN_W'(i);
            end
        endfunction

        function void note_event(func_t f, logic [PRIO_W-1:0] prio, logic [TICKS_W-1:0] ticks);
            sched_word_t w;
            status_t     st;
            st = ST_OK;
            case (f)
                FUNC_REGISTER: begin
                    if (prio >= THREADS) begin
                        st = ST_RANGE;
                    end else if (slot_used[prio]) begin
                        st = ST_TAKEN;
                    end else begin
                        slot_used[prio]  = 1'b1;
                        ready_bits[prio] = 1'b1;
                    end
                end
                FUNC_DELAY: begin
                    if (running >= THREADS) begin
                        st = ST_IDLE_DELAY;
                    end else begin
                        delay_left[running] = ticks;
                        ready_bits[running] = 1'b0;
                    end
                    pick_next();
                end
                FUNC_TICK: begin
                    for (int i = 0; i < THREADS; i++) begin
                        if (slot_used[i] && delay_left[i] != 0) begin
                            delay_left[i] = delay_left[i] - 1;
                            if (delay_left[i] == 0) begin
                                ready_bits[i] = 1'b1;
                                wakeups++;
                            end
                        end
                    end
                    pick_next();
                end
                default: begin
                    pick_next();
                end
            endcase
            func_count[f]++;
            status_count[st]++;
            w.thread = running;
            w.mask   = ready_bits;
            w.status = st;
            owed_words.push_back(w);
        endfunction

        function void report(string field, int unsigned exp_val, int unsigned act_val);
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field,
                     exp_val, act_val);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            sched_word_t w;
            words_checked++;
            if (owed_words.size() == 0) begin
                errors++;
                $display("%0t: result word %0h arrived with no event pending", $time, word);
                return;
            end
            w = owed_words.pop_front();
            if (word[RUN_W-1:0] !== w.thread)
                report("current_thread", w.thread, word[RUN_W-1:0]);
            if (word[RUN_W +: MASK_W] !== w.mask)
                report("ready_mask", w.mask, word[RUN_W +: MASK_W]);
            if (word[RUN_W+MASK_W +: STATUS_W] !== w.status)
                report("status", w.status, word[RUN_W+MASK_W +: STATUS_W]);
            if (word[M_DATA_W-1:RUN_W+MASK_W+STATUS_W] !== '0)
                report("pad bits", 0, word[M_DATA_W-1:RUN_W+MASK_W+STATUS_W]);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // priority_req[4:0], delay_ticks[36:5], zero[39:37]
    logic [FUNC_W-1:0]   s_tuser = '0;   // func[1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // current_thread[3:0], ready_mask[11:4], status[13:12]

    sched_predictor sched = new();
    int burst_left = 0;
    int rx_cycle   = 0;
    int rx_mode    = 0;

    priority_thread_scheduler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb_priority_thread_scheduler failed");
        $finish;
    end

    // result side: check accepted words, drive m_tready with one of four patterns re-picked at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sched.check_result(m_tdata);
        end
        rx_cycle++;
        if (rx_cycle % 300 == 0) begin
            rx_mode = $urandom_range(3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= (rx_cycle % 4) != 0;
            2: m_tready <= $urandom_range(1);
            default: m_tready <= (rx_cycle % 16) >= 10;
        endcase
    end

    task automatic send_event(input func_t f, input logic [PRIO_W-1:0] prio,
                              input logic [TICKS_W-1:0] ticks);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_DATA_W-PRIO_W-TICKS_W){1'b0}}, ticks, prio};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sched.note_event(f, prio, ticks);
        // bursts of random length separated by random gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
            burst_left = $urandom_range(3) == 0 ? $urandom_range(40, 10) : $urandom_range(6);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sched.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        func_t              f;
        logic [PRIO_W-1:0]  prio;
        logic [TICKS_W-1:0] ticks;
        int                 pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle corner cases, range and taken checks, parking and waking
        send_event(FUNC_RESCHEDULE, '0, '0);
        send_event(FUNC_DELAY, '0, 32'h1234_5678);
        send_event(FUNC_TICK, '0, '0);
        send_event(FUNC_REGISTER, 5'd31, '0);
        send_event(FUNC_REGISTER, PRIO_W'(THREADS), '0);
        send_event(FUNC_REGISTER, 5'd7, '0);
        send_event(FUNC_REGISTER, 5'd7, '0);
        send_event(FUNC_RESCHEDULE, '0, '0);
        send_event(FUNC_REGISTER, 5'd0, '0);
        send_event(FUNC_REGISTER, 5'd3, '0);
        send_event(FUNC_RESCHEDULE, '0, '0);
        send_event(FUNC_DELAY, '0, 32'hFFFF_FFFF);
        send_event(FUNC_DELAY, '0, 32'h0);         // parks slot 3 for good
        send_event(FUNC_DELAY, '0, 32'd2);
        send_event(FUNC_DELAY, '0, 32'd5);         // idle thread current, ignored
        send_event(FUNC_TICK, '0, '0);
        send_event(FUNC_TICK, '0, '0);
        send_event(FUNC_REGISTER, 5'd1, '0);
        send_event(FUNC_REGISTER, 5'd2, '0);
        send_event(FUNC_REGISTER, 5'd4, '0);
        send_event(FUNC_REGISTER, 5'd5, '0);
        send_event(FUNC_REGISTER, 5'd6, '0);
        send_event(FUNC_RESCHEDULE, '0, '0);
        drain_results();

        for (int n = 0; n < 1450; n++) begin
            pick = $urandom_range(99);
            if (pick < 20)      f = FUNC_REGISTER;
            else if (pick < 45) f = FUNC_DELAY;
            else if (pick < 85) f = FUNC_TICK;
            else                f = FUNC_RESCHEDULE;
            prio  = $urandom_range(1) ? PRIO_W'($urandom_range(31))
                                      : PRIO_W'($urandom_range(THREADS - 1));
            ticks = $urandom;
            if (f == FUNC_DELAY) begin
                // short sleeps keep threads cycling; rare zero or huge ones park a slot
                pick = $urandom_range(399);
                if (pick == 0)        ticks = '0;
                else if (pick == 1)   ticks = $urandom;
                else if (pick < 340)  ticks = $urandom_range(4, 1);
                else                  ticks = $urandom_range(40, 5);
            end
            send_event(f, prio, ticks);
            if (n % 300 == 299) drain_results();
        end

        drain_results();
        repeat (3 * THREADS) @(posedge aclk);

        $display("covered %0d registers, %0d delays, %0d ticks, %0d reschedules; %0d wakeups",
                 sched.func_count[FUNC_REGISTER], sched.func_count[FUNC_DELAY],
                 sched.func_count[FUNC_TICK], sched.func_count[FUNC_RESCHEDULE], sched.wakeups);
        $display("statuses: %0d ok, %0d out of range, %0d taken, %0d idle delay; %0d words checked",
                 sched.status_count[ST_OK], sched.status_count[ST_RANGE],
                 sched.status_count[ST_TAKEN], sched.status_count[ST_IDLE_DELAY],
                 sched.words_checked);
        if (sched.errors == 0 && sched.pending() == 0) begin
            $display("tb_priority_thread_scheduler passed");
        end else begin
            $display("tb_priority_thread_scheduler failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pts_pkg.sv
sv/pts_ctrl.sv
sv/pts_dpath.sv
sv/priority_thread_scheduler.sv
sim/tb_priority_thread_scheduler.sv
